### hdl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### hdl/cau_pkg.sv
// Opcodes, status codes and default sizes of the complex arithmetic unit.
package cau_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int PART_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_NEG  = 3'd4,
        OP_CONJ = 3'd5,
        OP_EQ   = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

endpackage

### hdl/cau_if.sv
// Operand and result channel interfaces of the complex arithmetic unit.
interface cau_in_if import cau_pkg::*; #(
    parameter int PART_WIDTH = PART_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [2:0]                   op;
    logic signed [PART_WIDTH-1:0] a_real;
    logic signed [PART_WIDTH-1:0] a_imag;
    logic signed [PART_WIDTH-1:0] b_real;
    logic signed [PART_WIDTH-1:0] b_imag;

    modport source (output valid, op, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, op, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if import cau_pkg::*; #(
    parameter int PART_WIDTH = PART_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [PART_WIDTH-1:0] res_real;
    logic signed [PART_WIDTH-1:0] res_imag;
    logic                         is_equal;
    logic [1:0]                   status;

    modport source (output valid, res_real, res_imag, is_equal, status, input ready);
    modport sink   (input valid, res_real, res_imag, is_equal, status, output ready);
endinterface

### hdl/complex_arithmetic_unit.sv
// Complex arithmetic unit: pipelined add, sub, mul, div, negate, conjugate, compare.
//
// One operand pair is taken per cycle while the input is ready. The depth of the pipe
// is set by the divider, a restoring divider that settles one quotient bit per stage
// for each of the real and imaginary parts; every op travels the same pipe, so results
// keep their order. Each stage holds while its successor is full and stalled, so
// bubbles close up and the input stays ready until every stage is occupied and the
// output stalls.
// Products use four half-width partial multipliers each, summed a stage later.

`include "assert_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int PART_WIDTH = PART_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);

    localparam int W    = PART_WIDTH;
    localparam int LW   = W / 2;
    localparam int HH   = W - LW;
    localparam int PW   = 2 * W;
    localparam int SW   = PW + 1;
    localparam int NW   = SW + FRAC_BITS;
    localparam int XW   = NW + W;
    localparam int DIV0 = 6;
    localparam int FIN  = W + 6;
    localparam int NST  = W + 7;

    localparam logic [W-1:0]  MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  MINP = {1'b1, {(W-1){1'b0}}};
    localparam logic [SW-1:0] LIMP = SW'(MAXP);
    localparam logic [SW-1:0] LIMN = LIMP + SW'(1);
    localparam logic [SW-1:0] HALF = (FRAC_BITS > 0) ? (SW'(1) << (FRAC_BITS - 1)) : '0;

    typedef struct packed {
        t_op                    op;
        logic signed [W-1:0]    ar;
        logic signed [W-1:0]    ai;
        logic signed [W-1:0]    br;
        logic signed [W-1:0]    bi;
        logic [5:0][2*HH-1:0]   phh;
        logic [5:0][HH+LW:0]    phl;
        logic [5:0][HH+LW:0]    plh;
        logic [5:0][2*LW-1:0]   pll;
        logic [5:0][PW-1:0]     pr;
        logic signed [SW-1:0]   vr;
        logic signed [SW-1:0]   vi;
        logic [PW-1:0]          den;
        logic                   dz;
        logic                   negr;
        logic                   negi;
        logic [SW-1:0]          magr;
        logic [SW-1:0]          magi;
        logic [NW-1:0]          remr;
        logic [NW-1:0]          remi;
        logic [W-1:0]           qr;
        logic [W-1:0]           qi;
        logic                   ovfr;
        logic                   ovfi;
        logic [W-1:0]           resr;
        logic [W-1:0]           resi;
        logic                   eq;
        logic                   sat;
        t_status                status;
    } t_stage;

    t_stage           r_st [NST];
    t_stage           n_st [NST];
    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   en;

    function automatic logic [W:0] f_wrap(input logic [W:0] v);
        logic ovf;
        logic [W-1:0] val;
        ovf = v[W] ^ v[W-1];
        val = ovf ? (v[W] ? MINP : MAXP) : v[W-1:0];
        return {ovf, val};
    endfunction

    function automatic logic [W:0] f_clamp(input logic neg, input logic [SW-1:0] mag);
        logic sat;
        logic [W-1:0] val;
        sat = neg ? (mag > LIMN) : (mag > LIMP);
        if (sat) begin
            val = neg ? MINP : MAXP;
        end else begin
            val = neg ? W'(-mag) : mag[W-1:0];
        end
        return {sat, val};
    endfunction

    function automatic logic [PW-1:0] f_prod(
        input logic [2*HH-1:0] hh,
        input logic [HH+LW:0]  hl,
        input logic [HH+LW:0]  lh,
        input logic [2*LW-1:0] ll
    );
        return (PW'($signed(hh)) << (2 * LW)) + (PW'($signed(hl)) << LW)
             + (PW'($signed(lh)) << LW) + PW'(ll);
    endfunction

    // hold a stage only while it is full and everything after it is stalled
    always_comb begin
        en[NST-1] = !r_vld[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_comb begin : p_s0
        n_st[0]    = '0;
        n_st[0].op = t_op'(i_in.op);
        n_st[0].ar = i_in.a_real;
        n_st[0].ai = i_in.a_imag;
        n_st[0].br = i_in.b_real;
        n_st[0].bi = i_in.b_imag;
    end

    always_comb begin : p_s1
        logic [5:0][W-1:0] mx;
        logic [5:0][W-1:0] my;
        logic [W:0]        sr;
        logic [W:0]        si;
        logic [W:0]        wr;
        logic [W:0]        wi;
        n_st[1] = r_st[0];
        mx = {r_st[0].bi, r_st[0].br, r_st[0].ar, r_st[0].br, r_st[0].ai, r_st[0].ar};
        my = {r_st[0].bi, r_st[0].br, r_st[0].bi, r_st[0].ai, r_st[0].bi, r_st[0].br};
        for (int j = 0; j < 6; j++) begin
            n_st[1].phh[j] = $signed(mx[j][W-1:LW]) * $signed(my[j][W-1:LW]);
            n_st[1].phl[j] = $signed(mx[j][W-1:LW]) * $signed({1'b0, my[j][LW-1:0]});
            n_st[1].plh[j] = $signed({1'b0, mx[j][LW-1:0]}) * $signed(my[j][W-1:LW]);
            n_st[1].pll[j] = mx[j][LW-1:0] * my[j][LW-1:0];
        end
        sr = '0;
        si = '0;
        n_st[1].eq = 1'b0;
        case (r_st[0].op)
            OP_ADD: begin
                sr = (W+1)'(r_st[0].ar) + (W+1)'(r_st[0].br);
                si = (W+1)'(r_st[0].ai) + (W+1)'(r_st[0].bi);
            end
            OP_SUB: begin
                sr = (W+1)'(r_st[0].ar) - (W+1)'(r_st[0].br);
                si = (W+1)'(r_st[0].ai) - (W+1)'(r_st[0].bi);
            end
            OP_NEG: begin
                sr = -(W+1)'(r_st[0].ar);
                si = -(W+1)'(r_st[0].ai);
            end
            OP_CONJ: begin
                sr = (W+1)'(r_st[0].ar);
                si = -(W+1)'(r_st[0].ai);
            end
            OP_EQ: begin
                n_st[1].eq = (r_st[0].ar == r_st[0].br) && (r_st[0].ai == r_st[0].bi);
            end
            default: begin
                sr = '0;
                si = '0;
            end
        endcase
        wr = f_wrap(sr);
        wi = f_wrap(si);
        n_st[1].resr = wr[W-1:0];
        n_st[1].resi = wi[W-1:0];
        n_st[1].sat  = wr[W] | wi[W];
    end

    always_comb begin : p_s2
        n_st[2] = r_st[1];
        for (int j = 0; j < 6; j++) begin
            n_st[2].pr[j] = f_prod(r_st[1].phh[j], r_st[1].phl[j], r_st[1].plh[j],
                                   r_st[1].pll[j]);
        end
    end

    always_comb begin : p_s3
        n_st[3] = r_st[2];
        if (r_st[2].op == OP_DIV) begin
            n_st[3].vr = SW'($signed(r_st[2].pr[0])) + SW'($signed(r_st[2].pr[1]));
            n_st[3].vi = SW'($signed(r_st[2].pr[2])) - SW'($signed(r_st[2].pr[3]));
        end else begin
            n_st[3].vr = SW'($signed(r_st[2].pr[0])) - SW'($signed(r_st[2].pr[1]));
            n_st[3].vi = SW'($signed(r_st[2].pr[2])) + SW'($signed(r_st[2].pr[3]));
        end
        n_st[3].den = r_st[2].pr[4] + r_st[2].pr[5];
    end

    always_comb begin : p_s4
        n_st[4]      = r_st[3];
        n_st[4].dz   = (r_st[3].den == '0);
        n_st[4].negr = r_st[3].vr[SW-1];
        n_st[4].negi = r_st[3].vi[SW-1];
        n_st[4].magr = r_st[3].vr[SW-1] ? SW'(-r_st[3].vr) : SW'(r_st[3].vr);
        n_st[4].magi = r_st[3].vi[SW-1] ? SW'(-r_st[3].vi) : SW'(r_st[3].vi);
    end

    always_comb begin : p_s5
        logic [SW-1:0] rmr;
        logic [SW-1:0] rmi;
        logic [W:0]    cr;
        logic [W:0]    ci;
        n_st[5] = r_st[4];
        rmr = (r_st[4].magr + HALF) >> FRAC_BITS;
        rmi = (r_st[4].magi + HALF) >> FRAC_BITS;
        cr  = f_clamp(r_st[4].negr, rmr);
        ci  = f_clamp(r_st[4].negi, rmi);
        if (r_st[4].op == OP_MUL) begin
            n_st[5].resr = cr[W-1:0];
            n_st[5].resi = ci[W-1:0];
            n_st[5].sat  = cr[W] | ci[W];
        end
        n_st[5].remr = NW'(r_st[4].magr) << FRAC_BITS;
        n_st[5].remi = NW'(r_st[4].magi) << FRAC_BITS;
        n_st[5].ovfr = (XW'(NW'(r_st[4].magr) << FRAC_BITS)) >= (XW'(r_st[4].den) << W);
        n_st[5].ovfi = (XW'(NW'(r_st[4].magi) << FRAC_BITS)) >= (XW'(r_st[4].den) << W);
        n_st[5].qr   = '0;
        n_st[5].qi   = '0;
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < W; k++) begin : g_div
        localparam int SH = W - 1 - k;
        always_comb begin : p_div
            logic [XW-1:0] dsh;
            n_st[DIV0+k] = r_st[DIV0+k-1];
            dsh = XW'(r_st[DIV0+k-1].den) << SH;
            if (XW'(r_st[DIV0+k-1].remr) >= dsh) begin
                n_st[DIV0+k].remr   = NW'(XW'(r_st[DIV0+k-1].remr) - dsh);
                n_st[DIV0+k].qr[SH] = 1'b1;
            end
            if (XW'(r_st[DIV0+k-1].remi) >= dsh) begin
                n_st[DIV0+k].remi   = NW'(XW'(r_st[DIV0+k-1].remi) - dsh);
                n_st[DIV0+k].qi[SH] = 1'b1;
            end
        end
    end

    always_comb begin : p_fin
        logic [W:0] qmr;
        logic [W:0] qmi;
        logic [W:0] cr;
        logic [W:0] ci;
        n_st[FIN] = r_st[FIN-1];
        qmr = (W+1)'(r_st[FIN-1].qr)
            + (W+1)'((XW'(r_st[FIN-1].remr) << 1) >= XW'(r_st[FIN-1].den));
        qmi = (W+1)'(r_st[FIN-1].qi)
            + (W+1)'((XW'(r_st[FIN-1].remi) << 1) >= XW'(r_st[FIN-1].den));
        cr  = f_clamp(r_st[FIN-1].negr, SW'(qmr));
        ci  = f_clamp(r_st[FIN-1].negi, SW'(qmi));
        if (r_st[FIN-1].ovfr) begin
            cr = {1'b1, (r_st[FIN-1].negr ? MINP : MAXP)};
        end
        if (r_st[FIN-1].ovfi) begin
            ci = {1'b1, (r_st[FIN-1].negi ? MINP : MAXP)};
        end
        if (r_st[FIN-1].op == OP_DIV) begin
            if (r_st[FIN-1].dz) begin
                n_st[FIN].resr = '0;
                n_st[FIN].resi = '0;
                n_st[FIN].sat  = 1'b0;
            end else begin
                n_st[FIN].resr = cr[W-1:0];
                n_st[FIN].resi = ci[W-1:0];
                n_st[FIN].sat  = cr[W] | ci[W];
            end
        end
        if (r_st[FIN-1].op == OP_DIV && r_st[FIN-1].dz) begin
            n_st[FIN].status = ST_DIV_ZERO;
        end else if (n_st[FIN].sat) begin
            n_st[FIN].status = ST_SAT;
        end else begin
            n_st[FIN].status = ST_OK;
        end
    end

    assign o_out.valid    = r_vld[FIN];
    assign o_out.res_real = r_st[FIN].resr;
    assign o_out.res_imag = r_st[FIN].resi;
    assign o_out.is_equal = r_st[FIN].eq;
    assign o_out.status   = r_st[FIN].status;

    `ASSERT_IMPLY(a_dz_zero, i_clk, i_rst_n, o_out.valid && o_out.status == ST_DIV_ZERO, o_out.res_real == '0 && o_out.res_imag == '0)
    `ASSERT_IMPLY(a_eq_clean, i_clk, i_rst_n, o_out.valid && o_out.is_equal, o_out.status == ST_OK && o_out.res_real == '0 && o_out.res_imag == '0)
    `ASSERT_IMPLY(a_full_stall, i_clk, i_rst_n, !i_in.ready, (&r_vld) && !o_out.ready)
    `ASSERT_NEXT(a_no_loss, i_clk, i_rst_n, r_vld[FIN] && !o_out.ready, r_vld[FIN])

endmodule

### sim/complex_arithmetic_unit_tb.sv
// Self-checking testbench for the complex arithmetic unit: random and directed operand pairs.
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int  FRAC    = FRAC_BITS_DEF;
    localparam int  W       = PART_WIDTH_DEF;
    localparam int  N_RAND  = 1300;
    localparam int  LIMIT   = 400000;
    localparam int  LATENCY = W + 7;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [W-1:0] part_t;

    typedef struct {
        logic [2:0] op;
        part_t      a_real;
        part_t      a_imag;
        part_t      b_real;
        part_t      b_imag;
        bit         drain;
    } operands_t;

    typedef struct {
        part_t      res_real;
        part_t      res_imag;
        logic       is_equal;
        logic [1:0] status;
    } answer_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cau_in_if  #(.PART_WIDTH(W)) in_if ();
    cau_out_if #(.PART_WIDTH(W)) out_if ();

    complex_arithmetic_unit #(.FRAC_BITS(FRAC), .PART_WIDTH(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #2 i_clk = ~i_clk;

    operands_t pending_q[$];
    answer_t   answer_q[$];
    int        errors = 0;
    int        n_in = 0;
    int        n_out = 0;
    int        op_count[8];
    int        cycles = 0;
    logic      in_fire = 1'b0;
    logic      out_fire = 1'b0;
    int        tx_wait = 0;
    int        rx_wait = 0;
    bit        tx_idle = 1'b1;
    bit        rx_idle = 1'b1;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        n_drain = 0;

    initial begin
        in_if.valid  = 1'b0;
        in_if.op     = '0;
        in_if.a_real = '0;
        in_if.a_imag = '0;
        in_if.b_real = '0;
        in_if.b_imag = '0;
        out_if.ready = 1'b0;
        foreach (op_count[k]) op_count[k] = 0;
    end

    function automatic part_t clamp(wide_t v, inout bit sat);
        wide_t hi, lo;
        hi = (wide_t'(1) <<< (W - 1)) - 1;
        lo = -(wide_t'(1) <<< (W - 1));
        if (v > hi) begin
            sat = 1'b1;
            return part_t'(hi);
        end
        if (v < lo) begin
            sat = 1'b1;
            return part_t'(lo);
        end
        return part_t'(v);
    endfunction

    function automatic wide_t round_frac(wide_t v);
        wide_t m;
        m = (v < 0) ? -v : v;
        m = (m + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
        return (v < 0) ? -m : m;
    endfunction

    function automatic wide_t quotient(wide_t n, wide_t den);
        wide_t m, q, r;
        m = (n < 0) ? -n : n;
        m = m <<< FRAC;
        q = m / den;
        r = m % den;
        if ((r <<< 1) >= den) q = q + 1;
        return (n < 0) ? -q : q;
    endfunction

    function automatic answer_t complex_result(operands_t it);
        answer_t res;
        wide_t   ar, ai, br, bi, rr, ri, den;
        bit      sat;
        ar = it.a_real;
        ai = it.a_imag;
        br = it.b_real;
        bi = it.b_imag;
        rr = 0;
        ri = 0;
        sat = 1'b0;
        res.is_equal = 1'b0;
        res.status = ST_OK;
        case (it.op)
            OP_ADD: begin
                rr = ar + br;
                ri = ai + bi;
            end
            OP_SUB: begin
                rr = ar - br;
                ri = ai - bi;
            end
            OP_MUL: begin
                rr = round_frac(ar * br - ai * bi);
                ri = round_frac(br * ai + ar * bi);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    res.status = ST_DIV_ZERO;
                end else begin
                    rr = quotient(ar * br + ai * bi, den);
                    ri = quotient(br * ai - ar * bi, den);
                end
            end
            OP_NEG: begin
                rr = -ar;
                ri = -ai;
            end
            OP_CONJ: begin
                rr = ar;
                ri = -ai;
            end
            OP_EQ: res.is_equal = (ar == br) && (ai == bi);
            default: ;
        endcase
        res.res_real = clamp(rr, sat);
        res.res_imag = clamp(ri, sat);
        if (sat && res.status == ST_OK) res.status = ST_SAT;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("[%0t] result %0d: %s got %0d, expected %0d", $time, n_out, what, got, want);
    endtask

    function automatic part_t random_part();
        case ($urandom_range(0, 9))
            0: return {1'b0, {(W-1){1'b1}}};
            1: return {1'b1, {(W-1){1'b0}}};
            2: return '0;
            3, 4: return part_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return part_t'($urandom);
        endcase
    endfunction

    function automatic operands_t make_item(logic [2:0] op, part_t ar, part_t ai,
                                            part_t br, part_t bi);
        operands_t it;
        it.op = op;
        it.a_real = ar;
        it.a_imag = ai;
        it.b_real = br;
        it.b_imag = bi;
        it.drain = 1'b0;
        return it;
    endfunction

    function automatic int draw_gap(bit idle_on);
        return idle_on ? $urandom_range(0, 15) : 0;
    endfunction

    // Sender: hold payload until the transfer, then idle for a drawn gap.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                tx_wait = draw_gap(tx_idle);
                if (n_in % 150 == 0) tx_idle = $urandom_range(0, 3) != 0;
            end
            if (!in_if.valid || in_fire) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    in_if.valid <= 1'b0;
                end else if (pending_q.size() > 0 &&
                             !(pending_q[0].drain && answer_q.size() != 0)) begin
                    operands_t it;
                    it = pending_q.pop_front();
                    if (it.drain) n_drain++;
                    in_if.op     <= it.op;
                    in_if.a_real <= it.a_real;
                    in_if.a_imag <= it.a_imag;
                    in_if.b_real <= it.b_real;
                    in_if.b_imag <= it.b_imag;
                    in_if.valid  <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once the pipe has seen some traffic.
    always @(negedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else if (!hold_done && n_in >= 400) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                rx_wait = draw_gap(rx_idle);
                if (n_out % 170 == 0) rx_idle = $urandom_range(0, 3) != 0;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     answer_q.size());
            $display("** complex_arithmetic_unit: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && in_if.valid && in_if.ready;
        out_fire <= i_rst_n && out_if.valid && out_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            answer_q.push_back(complex_result(make_item(in_if.op, in_if.a_real,
                               in_if.a_imag, in_if.b_real, in_if.b_imag)));
            op_count[in_if.op]++;
            n_in++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_out++;
            if (answer_q.size() == 0) begin
                errors++;
                $display("[%0t] result %0d arrived with nothing outstanding", $time, n_out);
            end else begin
                answer_t want;
                want = answer_q.pop_front();
                if (out_if.res_real !== want.res_real)
                    report_mismatch("res_real", out_if.res_real, want.res_real);
                if (out_if.res_imag !== want.res_imag)
                    report_mismatch("res_imag", out_if.res_imag, want.res_imag);
                if (out_if.is_equal !== want.is_equal)
                    report_mismatch("is_equal", out_if.is_equal, want.is_equal);
                if (out_if.status !== want.status)
                    report_mismatch("status", out_if.status, want.status);
            end
        end
    end

    initial begin
        part_t     pmax, pmin, one;
        operands_t it;
        pmax = {1'b0, {(W-1){1'b1}}};
        pmin = {1'b1, {(W-1){1'b0}}};
        one  = part_t'(1 << FRAC);

        pending_q.push_back(make_item(OP_ADD, pmax, pmax, pmax, pmax));
        pending_q.push_back(make_item(OP_ADD, pmin, pmin, pmin, pmin));
        pending_q.push_back(make_item(OP_ADD, one, -one, -one, one));
        pending_q.push_back(make_item(OP_SUB, pmax, pmin, pmin, pmax));
        pending_q.push_back(make_item(OP_SUB, 5, 7, 3, 9));
        pending_q.push_back(make_item(OP_MUL, pmax, pmax, pmax, pmin));
        pending_q.push_back(make_item(OP_MUL, pmin, pmin, pmin, pmin));
        pending_q.push_back(make_item(OP_MUL, one, one, one, -one));
        pending_q.push_back(make_item(OP_MUL, 1 << 7, 1, 1 << 8, 3));
        pending_q.push_back(make_item(OP_MUL, -(1 << 7), 0, 1 << 8, 0));
        pending_q.push_back(make_item(OP_DIV, one, one, 0, 0));
        pending_q.push_back(make_item(OP_DIV, pmax, pmin, 1, 0));
        pending_q.push_back(make_item(OP_DIV, pmin, pmin, pmin, pmin));
        pending_q.push_back(make_item(OP_DIV, one, 0, 3 * one, 0));
        pending_q.push_back(make_item(OP_DIV, -one, one, one, -2 * one));
        pending_q.push_back(make_item(OP_NEG, pmin, pmax, 0, 0));
        pending_q.push_back(make_item(OP_NEG, pmax, pmin, 0, 0));
        pending_q.push_back(make_item(OP_CONJ, pmin, pmin, 0, 0));
        pending_q.push_back(make_item(OP_CONJ, pmax, pmax, 0, 0));
        pending_q.push_back(make_item(OP_EQ, pmin, pmax, pmin, pmax));
        pending_q.push_back(make_item(OP_EQ, pmin, pmax, pmin, pmax - 1));
        pending_q.push_back(make_item(OP_UNUSED, pmax, pmin, pmax, pmin));

        for (int k = 0; k < N_RAND; k++) begin
            logic [2:0] op;
            op = ($urandom_range(0, 40) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
            it = make_item(op, random_part(), random_part(), random_part(), random_part());
            if (op == OP_EQ && $urandom_range(0, 1)) begin
                it.b_real = it.a_real;
                if ($urandom_range(0, 2) != 0) it.b_imag = it.a_imag;
            end
            if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
                it.b_real = '0;
                it.b_imag = '0;
            end
            it.drain = (k == 800);
            pending_q.push_back(it);
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_q.size() != 0 || in_if.valid || answer_q.size() != 0);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("%0d operand pairs in, %0d results out; add %0d sub %0d mul %0d div %0d",
                 n_in, n_out, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
                 op_count[OP_DIV]);
        $display("neg %0d conj %0d eq %0d unused %0d; drain pauses %0d, long stall %0d",
                 op_count[OP_NEG], op_count[OP_CONJ], op_count[OP_EQ],
                 op_count[OP_UNUSED], n_drain, hold_done);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("** complex_arithmetic_unit: PASSED **");
        end else begin
            $display("** complex_arithmetic_unit: FAILED **");
        end
        $finish;
    end

endmodule
